// File: rtl/pow_nonce_checker_unit_defines.svh
// Assertion macros shared by the proof-of-work checker RTL.
// No dependencies; included by the top level only.
`ifndef POW_NONCE_CHECKER_UNIT_DEFINES_SVH
`define POW_NONCE_CHECKER_UNIT_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define PNC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define PNC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pnc_pkg.sv
// Types, SHA-256 constants and round functions for the proof-of-work checker.
// No dependencies; used by pnc_compress and pow_nonce_checker_unit.
package pnc_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [0:7] state_t;
    typedef word_t [0:15] block_t;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  word_index;
        logic [63:0] word_value;
        logic [63:0] candidate_nonce;
    } pnc_in_t;

    typedef struct packed {
        logic        on_target;
        logic [63:0] tried_nonce;
        logic [63:0] hash_head;
    } pnc_out_t;

    localparam logic       REQ_LOAD      = 1'b0;
    localparam logic       REQ_TRY       = 1'b1;
    localparam int         PREFIX_WORDS  = 10;
    localparam logic [31:0] COMPACT_RESET = 32'h1d00ffff;
    localparam word_t      PAD_WORD      = 32'h80000000;
    localparam word_t      LEN_HEADER    = 32'd704;
    localparam word_t      LEN_DIGEST    = 32'd256;

    localparam state_t IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t [0:63] RK = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(word_t x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic state_t sha_round(state_t s, word_t w, word_t k);
        word_t  t1;
        word_t  t2;
        state_t r;
        t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
           + ((s[4] & s[5]) ^ (~s[4] & s[6])) + k + w;
        t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
           + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
        r[0] = t1 + t2;
        r[1] = s[0];
        r[2] = s[1];
        r[3] = s[2];
        r[4] = s[3] + t1;
        r[5] = s[4];
        r[6] = s[5];
        r[7] = s[6];
        return r;
    endfunction

    function automatic block_t sched_next(block_t w);
        block_t r;
        for (int i = 0; i < 15; i++) begin
            r[i] = w[i + 1];
        end
        r[15] = w[0] + (rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3)) + w[9]
              + (rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10));
        return r;
    endfunction

    // Header bytes are stored lowest first; message words are big-endian.
    function automatic word_t lo_word(logic [63:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic word_t hi_word(logic [63:0] v);
        return {v[39:32], v[47:40], v[55:48], v[63:56]};
    endfunction

endpackage

// File: rtl/pnc_compress.sv
// One SHA-256 compression as a 64-stage round pipeline plus a final add stage.
// Depends on pnc_pkg; carries a side word alongside each block.
module pnc_compress
    import pnc_pkg::*;
#(
    parameter int SIDE_W = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  state_t            in_state,
    input  block_t            in_block,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output state_t            out_state,
    output logic [SIDE_W-1:0] out_side
);

    typedef struct packed {
        state_t            st;
        state_t            init;
        block_t            w;
        logic [SIDE_W-1:0] side;
    } stage_t;

    stage_t            stage_in [0:64];
    stage_t            pipe_reg [1:64];
    logic              vld_reg  [1:64];
    logic              vld_in   [0:64];
    logic              out_valid_reg;
    state_t            out_state_reg;
    logic [SIDE_W-1:0] out_side_reg;

    assign stage_in[0] = '{st: in_state, init: in_state, w: in_block, side: in_side};
    assign vld_in[0]   = in_valid;

    for (genvar r = 0; r < 64; r++) begin : g_round
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[r + 1] <= 1'b0;
            end else if (en) begin
                vld_reg[r + 1] <= vld_in[r];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pipe_reg[r + 1].st   <= sha_round(stage_in[r].st, stage_in[r].w[0], RK[r]);
                pipe_reg[r + 1].w    <= sched_next(stage_in[r].w);
                pipe_reg[r + 1].init <= stage_in[r].init;
                pipe_reg[r + 1].side <= stage_in[r].side;
            end
        end

        assign stage_in[r + 1] = pipe_reg[r + 1];
        assign vld_in[r + 1]   = vld_reg[r + 1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vld_in[64];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 8; i++) begin
                out_state_reg[i] <= stage_in[64].st[i] + stage_in[64].init[i];
            end
            out_side_reg <= stage_in[64].side;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_state = out_state_reg;
    assign out_side  = out_side_reg;

endmodule

// File: rtl/pow_nonce_checker_unit.sv
// Top level of the double SHA-256 proof-of-work nonce checker.
// Depends on pnc_pkg, pnc_compress and pow_nonce_checker_unit_defines.svh.
//
//  Channel  Ports                          Word
//  input    s_valid s_ready s_data         pnc_in_t: header load or nonce try
//  result   m_valid m_ready m_data         pnc_out_t: one per try
//  config   cfg_valid cfg_ready cfg_data   compact difficulty, 32 bits
//
// A try passes three compressions of 65 stages each and an output stage.
// A word enters per cycle unless a result stalls; loads pass no data down the pipeline.
// The whole pipeline advances together and holds while a result waits unaccepted.
// Reset clears valid bits and loads the compact register; header words stay undefined.
`include "pow_nonce_checker_unit_defines.svh"

module pow_nonce_checker_unit
    import pnc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pnc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output pnc_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [63:0]  prefix_reg [0:PREFIX_WORDS-1];
    logic [31:0]  compact_reg;
    logic [255:0] target_reg;
    logic [255:0] target_next;
    logic         m_valid_reg;
    pnc_out_t     m_data_reg;
    logic         en;
    logic         try_in;

    logic         c1_valid;
    state_t       c1_state;
    logic [191:0] c1_side;
    logic         c2_valid;
    state_t       c2_state;
    logic [63:0]  c2_side;
    logic         c3_valid;
    state_t       c3_state;
    logic [63:0]  c3_side;

    logic [7:0]   t_exp;
    logic [23:0]  t_mant;
    logic [4:0]   t_shift;

    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign try_in    = s_valid && s_ready && (s_data.req_type == REQ_TRY);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && (s_data.req_type == REQ_LOAD)) begin
            for (int i = 0; i < PREFIX_WORDS; i++) begin
                if (s_data.word_index == 4'(i)) begin
                    prefix_reg[i] <= s_data.word_value;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compact_reg <= COMPACT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            compact_reg <= cfg_data;
        end
    end

    always_comb begin
        t_exp   = compact_reg[31:24];
        t_mant  = {1'b0, compact_reg[22:0]};
        t_shift = 5'd29;
        if (t_exp <= 8'd3) begin
            case (t_exp[1:0])
                2'd0:    target_next = '0;
                2'd1:    target_next = {248'b0, t_mant[23:16]};
                2'd2:    target_next = {240'b0, t_mant[23:8]};
                default: target_next = {232'b0, t_mant};
            endcase
        end else begin
            if (t_exp < 8'd32) begin
                t_shift = 5'(t_exp - 8'd3);
            end
            target_next = {232'b0, t_mant} << {t_shift, 3'b000};
        end
    end

    always_ff @(posedge aclk) begin
        target_reg <= target_next;
    end

    pnc_compress #(.SIDE_W(192)) u_first (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (try_in),
        .in_state  (IV),
        .in_block  ({lo_word(prefix_reg[0]), hi_word(prefix_reg[0]),
                     lo_word(prefix_reg[1]), hi_word(prefix_reg[1]),
                     lo_word(prefix_reg[2]), hi_word(prefix_reg[2]),
                     lo_word(prefix_reg[3]), hi_word(prefix_reg[3]),
                     lo_word(prefix_reg[4]), hi_word(prefix_reg[4]),
                     lo_word(prefix_reg[5]), hi_word(prefix_reg[5]),
                     lo_word(prefix_reg[6]), hi_word(prefix_reg[6]),
                     lo_word(prefix_reg[7]), hi_word(prefix_reg[7])}),
        .in_side   ({s_data.candidate_nonce, prefix_reg[8], prefix_reg[9]}),
        .out_valid (c1_valid),
        .out_state (c1_state),
        .out_side  (c1_side)
    );

    pnc_compress #(.SIDE_W(64)) u_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c1_valid),
        .in_state  (c1_state),
        .in_block  ({lo_word(c1_side[127:64]), hi_word(c1_side[127:64]),
                     lo_word(c1_side[63:0]), hi_word(c1_side[63:0]),
                     lo_word(c1_side[191:128]), hi_word(c1_side[191:128]),
                     PAD_WORD, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                     LEN_HEADER}),
        .in_side   (c1_side[191:128]),
        .out_valid (c2_valid),
        .out_state (c2_state),
        .out_side  (c2_side)
    );

    pnc_compress #(.SIDE_W(64)) u_outer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c2_valid),
        .in_state  (IV),
        .in_block  ({c2_state[0], c2_state[1], c2_state[2], c2_state[3],
                     c2_state[4], c2_state[5], c2_state[6], c2_state[7],
                     PAD_WORD, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, LEN_DIGEST}),
        .in_side   (c2_side),
        .out_valid (c3_valid),
        .out_state (c3_state),
        .out_side  (c3_side)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= c3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.on_target   <= (c3_state <= target_reg);
            m_data_reg.tried_nonce <= c3_side;
            m_data_reg.hash_head   <= {c3_state[0], c3_state[1]};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PNC_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready, "input taken while result stalled")
    `PNC_ASSERT_NEXT(a_load_stored, aclk, aresetn, s_valid && s_ready && (s_data.req_type == REQ_LOAD) && (s_data.word_index < 4'd10), prefix_reg[$past(s_data.word_index)] == $past(s_data.word_value), "header word not stored")
    `PNC_ASSERT_NOW(a_rise_needs_advance, aclk, aresetn, $rose(m_valid), $past(s_ready), "result appeared without pipeline advance")

endmodule
